[hdl/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// Light pulse classifier package
// Shared types and constants for the majority filter and the pulse-width
// classifier.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Width of the millisecond counter and of the reported pulse length.
    localparam int unsigned MS_W = 16;

    // Width of the tick period register.
    localparam int unsigned TICK_W = 8;

    // Saturation value of the millisecond counter.
    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    // Reset value of the tick period register.
    localparam logic [TICK_W-1:0] TICK_MS_RESET = 8'd7;

    // Class band bounds in milliseconds; all bounds are exclusive.
    localparam logic [MS_W-1:0] POSTER_MARK_LO = 16'd30;
    localparam logic [MS_W-1:0] POSTER_MARK_HI = 16'd60;
    localparam logic [MS_W-1:0] POSTER_TOP_LO  = 16'd95;
    localparam logic [MS_W-1:0] POSTER_TOP_HI  = 16'd135;
    localparam logic [MS_W-1:0] WHITE_MARK_LO  = 16'd1350;
    localparam logic [MS_W-1:0] WHITE_MARK_HI  = 16'd1750;
    localparam logic [MS_W-1:0] NEXT_POSTER_LO = 16'd2600;
    localparam logic [MS_W-1:0] NEXT_POSTER_HI = 16'd3200;

    // Pulse classes as reported on the result channel.
    typedef enum logic [2:0] {
        CLASS_NONE        = 3'd0,
        CLASS_POSTER_MARK = 3'd1,
        CLASS_POSTER_TOP  = 3'd2,
        CLASS_WHITE_MARK  = 3'd3,
        CLASS_NEXT_POSTER = 3'd4
    } pulse_class_t;

    // Sort a pulse length into its class band.
    function automatic pulse_class_t classify(input logic [MS_W-1:0] t);
        pulse_class_t cls;
        cls = CLASS_NONE;
        if (t > POSTER_MARK_LO && t < POSTER_MARK_HI)
        begin
            cls = CLASS_POSTER_MARK;
        end
        else if (t > POSTER_TOP_LO && t < POSTER_TOP_HI)
        begin
            cls = CLASS_POSTER_TOP;
        end
        else if (t > WHITE_MARK_LO && t < WHITE_MARK_HI)
        begin
            cls = CLASS_WHITE_MARK;
        end
        else if (t > NEXT_POSTER_LO && t < NEXT_POSTER_HI)
        begin
            cls = CLASS_NEXT_POSTER;
        end
        return cls;
    endfunction

endpackage

[hdl/light_pulse_classifier.sv]
// Requests pass the read stage, then the output register. One request per
// cycle is taken unless output stalls; the ring memory is read at accept and
// written back by the read stage, so consecutive requests never touch the
// same entry. Reset (rst_n low, asynchronous) empties the pipeline, marks all
// ring entries as zero through per-entry valid bits, and sets tick_ms to 7.
// ----------------------------------------------------------------------------
// Light pulse classifier
// Majority filter over the last WINDOW sensor samples, with a millisecond
// counter that measures and classifies the time between filtered edges.
// ----------------------------------------------------------------------------
module light_pulse_classifier #(
    parameter int unsigned WINDOW = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration port for tick_ms.
    input  logic                          cfg_we,
    input  logic [lpc_pkg::TICK_W-1:0]    cfg_wdata,

    // Sample request channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          sensor_bit,

    // Result request channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          edge_seen,
    output logic                          filtered_level,
    output logic [lpc_pkg::MS_W-1:0]      pulse_ms,
    output logic [2:0]                    pulse_class
);

    import lpc_pkg::*;

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] THRESHOLD = CNT_W'(WINDOW / 2);

    // Configuration and filter state.
    logic [TICK_W-1:0] tick_ms_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [CNT_W-1:0]  ones_reg;
    logic              level_before_reg;
    logic [MS_W-1:0]   elapsed_reg;

    // Sample ring memory and its per-entry valid bits.
    logic              ring_mem [WINDOW];
    logic [WINDOW-1:0] ring_vld_reg;

    // Read stage.
    logic              s1_valid_reg;
    logic              s1_bit_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_rd_bit_reg;
    logic              s1_rd_vld_reg;

    // Output register.
    logic              out_valid_reg;
    logic              edge_seen_reg;
    logic              filtered_level_reg;
    logic [MS_W-1:0]   pulse_ms_reg;
    pulse_class_t      pulse_class_reg;

    // Handshake and update logic.
    logic              in_accept;
    logic              s1_move;
    logic              old_bit;
    logic [CNT_W-1:0]  ones_next;
    logic              level_next;
    logic [MS_W:0]     elapsed_sum;
    logic [MS_W-1:0]   elapsed_sat;
    logic              edge_next;

    // The read stage moves on whenever the output register is free or drained.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    // An entry never written since reset reads as zero.
    assign old_bit = s1_rd_vld_reg & s1_rd_bit_reg;

    // Running count of ones: add the new sample, drop the one it replaces.
    assign ones_next  = ones_reg + CNT_W'(s1_bit_reg) - CNT_W'(old_bit);
    assign level_next = (ones_next >= THRESHOLD);
    assign edge_next  = (level_next != level_before_reg);

    // Saturating millisecond counter.
    assign elapsed_sum = {1'b0, elapsed_reg} + (MS_W+1)'(tick_ms_reg);
    assign elapsed_sat = elapsed_sum[MS_W] ? MS_MAX : elapsed_sum[MS_W-1:0];

    // Tick period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg <= TICK_MS_RESET;
        end
        else if (cfg_we)
        begin
            tick_ms_reg <= cfg_wdata;
        end
    end

    // Ring memory write-back when the read stage moves on.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            ring_mem[s1_idx_reg] <= s1_bit_reg;
        end
    end

    // Ring memory read at accept; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_rd_bit_reg <= ring_mem[wr_idx_reg];
            s1_bit_reg    <= sensor_bit;
            s1_idx_reg    <= wr_idx_reg;
        end
    end

    // Valid bits of the ring, read beside the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg  <= '0;
            s1_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                ring_vld_reg[s1_idx_reg] <= 1'b1;
            end
            if (in_accept)
            begin
                s1_rd_vld_reg <= ring_vld_reg[wr_idx_reg];
            end
        end
    end

    // Pipeline control, write pointer and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            wr_idx_reg       <= '0;
            ones_reg         <= '0;
            level_before_reg <= 1'b0;
            elapsed_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                wr_idx_reg   <= (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + IDX_W'(1);
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                ones_reg         <= ones_next;
                level_before_reg <= level_next;
                elapsed_reg      <= edge_next ? '0 : elapsed_sat;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            edge_seen_reg      <= edge_next;
            filtered_level_reg <= level_next;
            pulse_ms_reg       <= edge_next ? elapsed_sat : '0;
            pulse_class_reg    <= edge_next ? classify(elapsed_sat) : CLASS_NONE;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_seen      = edge_seen_reg;
    assign filtered_level = filtered_level_reg;
    assign pulse_ms       = pulse_ms_reg;
    assign pulse_class    = pulse_class_reg;

    // The running count can never exceed the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg <= CNT_W'(WINDOW))
    else $error("ones count exceeds window size");

    // A held result always matches the level the filter remembers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_before_reg == filtered_level_reg))
    else $error("result level differs from stored level");

    // Without an edge the result carries no pulse length and no class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !edge_seen_reg) |->
            (pulse_ms_reg == '0 && pulse_class_reg == CLASS_NONE))
    else $error("pulse reported without an edge");

    // Input is stalled only while the read stage holds a request and out_stall holds the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
    else $error("input stalled without a blocked request");

endmodule
